// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_CLKED(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Clocked assertion on the default clk_i / rst_ni pair.
`define ASSERT_DEF(lbl, prop) `ASSERT_CLKED(lbl, clk_i, rst_ni, prop)

`endif

// ----- sv/itrc_pkg.sv -----
`timescale 1ns / 1ps

package itrc_pkg;

  localparam int unsigned IP_HEADER_WORDS = 10;

  localparam logic [15:0] IDX_CSUM_WORD  = 16'd5;
  localparam logic [15:0] IDX_SRC_HI     = 16'd6;
  localparam logic [15:0] IDX_SRC_LO     = 16'd7;
  localparam logic [15:0] IDX_DST_LO     = 16'd9;
  localparam logic [15:0] IDX_TOT_LEN    = 16'd1;
  localparam logic [15:0] TCP_CSUM_BASE  = 16'd8;
  localparam logic [15:0] PROTO_TCP      = 16'd6;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [15:0] ODD_BYTE_MASK  = 16'hFF00;
  localparam logic [15:0] IDX_MAX        = 16'hFFFF;

  typedef struct packed {
    logic [15:0] out_word;
    logic        out_last;
    logic [15:0] ip_check;
    logic [15:0] tcp_check;
    logic        pkt_status;
  } result_t;

  // End-around carry fold of up to eight 16-bit addends into 16 bits.
  function automatic logic [15:0] fold19(input logic [18:0] x);
    logic [16:0] t;
    logic [16:0] r;
    t = {1'b0, x[15:0]} + {14'd0, x[18:16]};
    r = {1'b0, t[15:0]} + {16'd0, t[16]};
    return r[15:0];
  endfunction

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

// ----- sv/itrc_in_reg.sv -----
`timescale 1ns / 1ps

module itrc_in_reg
  import itrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pkt_word_i,
  input  logic        pkt_last_i,
  input  logic        down_ready_i,
  output logic        valid_o,
  output logic [15:0] word_o,
  output logic        last_o
);

  logic        valid_q, valid_d;
  logic [15:0] word_q;
  logic        last_q;
  logic        load;

  assign in_stall_o = valid_q && !down_ready_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= pkt_word_i;
      last_q <= pkt_last_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign last_o  = last_q;

endmodule

// ----- sv/itrc_core.sv -----
`timescale 1ns / 1ps

module itrc_core
  import itrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [15:0] word_i,
  input  logic        last_i,
  input  logic [15:0] addr_offset_i,
  output result_t     res_o
);

  `include "assert_macros.svh"

  logic [15:0] widx_q, widx_d;
  logic [3:0]  hw_q, hw_d;
  logic [15:0] tl_q, tl_d;
  logic [15:0] ip_q, ip_d;
  logic [15:0] tcp_q, tcp_d;

  logic [15:0] idx;
  logic [3:0]  hw_eff;
  logic [15:0] tl_eff;
  logic [15:0] sw_add;
  logic [15:0] rw;
  logic [15:0] ipv;
  logic [15:0] o_word;
  logic [5:0]  hb;
  logic [16:0] b;
  logic        in_seg;
  logic [15:0] ip_add;
  logic [15:0] ps_add;
  logic [15:0] seg_add;
  logic [15:0] seg_len;
  logic        short_pkt;
  logic [18:0] tcp_raw;
  logic [18:0] tcp_fin_raw;
  logic [15:0] ip_next;
  logic [15:0] tcp_next;

  assign idx    = widx_q;
  assign hw_eff = (idx == 16'd0) ? word_i[11:8] : hw_q;
  assign tl_eff = (idx == IDX_TOT_LEN) ? word_i : tl_q;

  assign sw_add = swap16(word_i) + addr_offset_i;

  always_comb begin
    rw = word_i;
    if (idx == IDX_SRC_LO || idx == IDX_DST_LO) begin
      rw = swap16(sw_add);
    end
    ipv    = (idx == IDX_CSUM_WORD) ? 16'd0 : rw;
    o_word = (idx == ({11'd0, hw_eff, 1'b0} + TCP_CSUM_BASE)) ? 16'd0 : ipv;
  end

  assign hb     = {hw_eff, 2'b00};
  assign b      = {idx, 1'b0};
  assign in_seg = (b >= {11'd0, hb}) && (b < {1'b0, tl_eff});

  always_comb begin
    ip_add  = (idx < 16'(IP_HEADER_WORDS)) ? ipv : 16'd0;
    ps_add  = (idx >= IDX_SRC_HI && idx <= IDX_DST_LO) ? rw : 16'd0;
    seg_add = 16'd0;
    if (in_seg) begin
      seg_add = ({idx, 1'b1} < {1'b0, tl_eff}) ? o_word : (o_word & ODD_BYTE_MASK);
    end
  end

  assign seg_len   = (tl_eff >= {10'd0, hb}) ? (tl_eff - {10'd0, hb}) : 16'd0;
  assign short_pkt = ({1'b0, idx, 1'b0} + 18'd2) < {2'b00, tl_eff};

  assign ip_next     = fold19({3'd0, ip_q} + {3'd0, ip_add});
  assign tcp_raw     = {3'd0, tcp_q} + {3'd0, ps_add} + {3'd0, seg_add};
  assign tcp_next    = fold19(tcp_raw);
  assign tcp_fin_raw = tcp_raw + {3'd0, PROTO_TCP} + {3'd0, seg_len};

  always_comb begin
    res_o.out_word   = o_word;
    res_o.out_last   = last_i;
    res_o.ip_check   = 16'd0;
    res_o.tcp_check  = 16'd0;
    res_o.pkt_status = 1'b0;
    if (last_i) begin
      res_o.ip_check   = ~ip_next;
      res_o.tcp_check  = ~fold19(tcp_fin_raw);
      res_o.pkt_status = (hw_eff < MIN_IHL) || (tl_eff < {10'd0, hb}) || short_pkt;
    end
  end

  always_comb begin
    widx_d = widx_q;
    hw_d   = hw_q;
    tl_d   = tl_q;
    ip_d   = ip_q;
    tcp_d  = tcp_q;
    if (fire_i) begin
      if (last_i) begin
        widx_d = 16'd0;
        hw_d   = 4'd0;
        tl_d   = 16'd0;
        ip_d   = 16'd0;
        tcp_d  = 16'd0;
      end else begin
        widx_d = (widx_q == IDX_MAX) ? IDX_MAX : widx_q + 16'd1;
        hw_d   = hw_eff;
        tl_d   = tl_eff;
        ip_d   = ip_next;
        tcp_d  = tcp_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= 16'd0;
      hw_q   <= 4'd0;
      tl_q   <= 16'd0;
      ip_q   <= 16'd0;
      tcp_q  <= 16'd0;
    end else begin
      widx_q <= widx_d;
      hw_q   <= hw_d;
      tl_q   <= tl_d;
      ip_q   <= ip_d;
      tcp_q  <= tcp_d;
    end
  end

  `ASSERT_DEF(a_clear_after_last,
    fire_i && last_i |=> widx_q == 16'd0 && ip_q == 16'd0 && tcp_q == 16'd0)
  `ASSERT_DEF(a_index_steps,
    fire_i && !last_i && widx_q != IDX_MAX |=> widx_q == $past(widx_q) + 16'd1)
  `ASSERT_DEF(a_idle_holds,
    !fire_i |=> $stable(widx_q) && $stable(ip_q) && $stable(tcp_q))

endmodule

// ----- sv/ipv4_tcp_rewrite_checksum_top.sv -----
`timescale 1ns / 1ps
// A transaction accepted into the input register moves on into the result register, which
// drives the outputs. Throughput: one word per cycle while out_stall_i is low; the input
// register and the result register decouple the two sides, and the per-word sum and
// rewrite logic sits between them.
// Reset (rst_ni, async, active low): addr_offset returns to 0, packet state and both
// running sums return to 0, both pipeline stages empty. No clearing pass.
module ipv4_tcp_rewrite_checksum_top
  import itrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] pkt_word_i,
  input  logic        pkt_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_word_o,
  output logic        out_last_o,
  output logic [15:0] ip_check_o,
  output logic [15:0] tcp_check_o,
  output logic        pkt_status_o
);

  `include "assert_macros.svh"

  logic [15:0] addr_offset_q;
  logic        s1_valid;
  logic [15:0] s1_word;
  logic        s1_last;
  logic        adv;
  logic        fire;
  result_t     res;
  result_t     res_q;
  logic        out_valid_q, out_valid_d;

  assign adv  = !out_valid_q || !out_stall_i;
  assign fire = s1_valid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_offset_q <= 16'd0;
    end else if (cfg_we_i) begin
      addr_offset_q <= cfg_wdata_i;
    end
  end

  itrc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pkt_word_i  (pkt_word_i),
    .pkt_last_i  (pkt_last_i),
    .down_ready_i(adv),
    .valid_o     (s1_valid),
    .word_o      (s1_word),
    .last_o      (s1_last)
  );

  itrc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .word_i       (s1_word),
    .last_i       (s1_last),
    .addr_offset_i(addr_offset_q),
    .res_o        (res)
  );

  assign out_valid_d = adv ? s1_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_word_o   = res_q.out_word;
  assign out_last_o   = res_q.out_last;
  assign ip_check_o   = res_q.ip_check;
  assign tcp_check_o  = res_q.tcp_check;
  assign pkt_status_o = res_q.pkt_status;

  `ASSERT_DEF(a_no_invented_result,
    out_valid_q && !out_stall_i && !s1_valid |=> !out_valid_q)
  `ASSERT_DEF(a_stage_moves,
    fire |=> out_valid_q)
  `ASSERT_DEF(a_stall_only_when_full,
    in_stall_o |-> s1_valid && out_valid_q && out_stall_i)

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import itrc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned PHASE_WORDS = 140;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic        typed;
    result_t     res;
  } stim_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        in_valid_i  = 1'b0;
  logic [15:0] pkt_word_i  = 16'h0000;
  logic        pkt_last_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] out_word_o;
  logic        out_last_o;
  logic [15:0] ip_check_o;
  logic [15:0] tcp_check_o;
  logic        pkt_status_o;

  ipv4_tcp_rewrite_checksum_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pkt_word_i  (pkt_word_i),
    .pkt_last_i  (pkt_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .out_last_o  (out_last_o),
    .ip_check_o  (ip_check_o),
    .tcp_check_o (tcp_check_o),
    .pkt_status_o(pkt_status_o)
  );

  always #1 clk_i = ~clk_i;

  // shadow of the block state
  logic [15:0] addr_off  = 16'h0000;
  logic [15:0] word_idx  = 16'h0000;
  logic [3:0]  hdr_words = 4'h0;
  logic [15:0] tot_len   = 16'h0000;
  logic [15:0] ip_acc    = 16'h0000;
  logic [15:0] tcp_acc   = 16'h0000;

  result_t     pending_words[$];
  int unsigned fail_count   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  bit          hold_req     = 1'b0;
  bit          hold_done    = 1'b0;
  int unsigned hold_left    = 0;

  stim_row_t dir_rows [25] = '{
    '{16'h0000, 1'b1, 1'b1, '{16'h0000, 1'b1, 16'hFFFF, 16'hFFF9, 1'b1}},
    '{16'hFFFF, 1'b1, 1'b1, '{16'hFFFF, 1'b1, 16'h0000, 16'hFFF9, 1'b1}},
    // odd total length, carries in both address words, one trailing word
    '{16'h4500, 1'b0, 1'b0, '0},
    '{16'h0017, 1'b0, 1'b0, '0},
    '{16'h1C46, 1'b0, 1'b0, '0},
    '{16'h4000, 1'b0, 1'b0, '0},
    '{16'h4006, 1'b0, 1'b0, '0},
    '{16'hB1E6, 1'b0, 1'b0, '0},
    '{16'hAC10, 1'b0, 1'b0, '0},
    '{16'hFF63, 1'b0, 1'b0, '0},
    '{16'hAC10, 1'b0, 1'b0, '0},
    '{16'hFFFF, 1'b0, 1'b0, '0},
    '{16'h3039, 1'b0, 1'b0, '0},
    '{16'hABCD, 1'b0, 1'b0, '0},
    '{16'h5A5A, 1'b1, 1'b0, '0},
    // header length 3, total length below the header
    '{16'h4300, 1'b0, 1'b0, '0},
    '{16'h0008, 1'b0, 1'b0, '0},
    '{16'h1234, 1'b0, 1'b0, '0},
    '{16'h8001, 1'b1, 1'b0, '0},
    // truncated packet
    '{16'h4600, 1'b0, 1'b0, '0},
    '{16'h0064, 1'b0, 1'b0, '0},
    '{16'h0000, 1'b0, 1'b0, '0},
    '{16'h4000, 1'b0, 1'b0, '0},
    '{16'h4006, 1'b0, 1'b0, '0},
    '{16'h7FFF, 1'b1, 1'b0, '0}
  };

  function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, v};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic void rewrite_step(input logic [15:0] w, input logic last,
                                       output result_t r);
    logic [15:0] rw, ipv, o, sw, seg, s;
    int unsigned ix, hw, tl, hb, b;
    ix = word_idx;
    if (ix == 0) hdr_words = w[11:8];
    if (ix == IDX_TOT_LEN) tot_len = w;
    hw = hdr_words;
    tl = tot_len;
    rw = w;
    if (ix == IDX_SRC_LO || ix == IDX_DST_LO) begin
      sw = {w[7:0], w[15:8]} + addr_off;
      rw = {sw[7:0], sw[15:8]};
    end
    ipv = (ix == IDX_CSUM_WORD) ? 16'h0000 : rw;
    o = ipv;
    if (ix == hw * 2 + TCP_CSUM_BASE) o = 16'h0000;
    if (ix < IP_HEADER_WORDS) ip_acc = oc_add(ip_acc, ipv);
    if (ix >= IDX_SRC_HI && ix <= IDX_DST_LO) tcp_acc = oc_add(tcp_acc, rw);
    hb = hw * 4;
    b = ix * 2;
    if (b >= hb && b < tl) begin
      tcp_acc = oc_add(tcp_acc, (b + 1 < tl) ? o : (o & ODD_BYTE_MASK));
    end
    r = '{o, last, 16'h0000, 16'h0000, 1'b0};
    if (last) begin
      seg = (tl >= hb) ? 16'(tl - hb) : 16'h0000;
      s = oc_add(oc_add(tcp_acc, PROTO_TCP), seg);
      r.ip_check = ~ip_acc;
      r.tcp_check = ~s;
      r.pkt_status = (hw < MIN_IHL || tl < hb || (ix + 1) * 2 < tl);
      word_idx = '0;
      hdr_words = '0;
      tot_len = '0;
      ip_acc = '0;
      tcp_acc = '0;
    end else if (word_idx != IDX_MAX) begin
      word_idx = word_idx + 16'd1;
    end
  endfunction

  task automatic send_word(input logic [15:0] w, input logic last, input logic typed,
                           input result_t typed_res);
    result_t p;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pkt_word_i <= w;
    pkt_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rewrite_step(w, last, p);
    pending_words.push_back(typed ? typed_res : p);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [15:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    addr_off = v;
  endtask

  // mostly well-formed packets, some truncated or padded, some garbage
  task automatic send_packet(output int unsigned n);
    int unsigned kind, ihl, tl, full, i;
    logic [15:0] w;
    kind = $urandom_range(99);
    ihl = ($urandom_range(19) == 0) ? $urandom_range(15, 8) : $urandom_range(7, 5);
    tl = ihl * 4 + $urandom_range(48);
    full = (tl + 1) / 2;
    if (kind < 75) n = full;
    else if (kind < 80) n = (full > 1) ? $urandom_range(full - 1, 1) : 1;
    else if (kind < 85) n = full + $urandom_range(3, 1);
    else n = $urandom_range(30, 1);
    for (i = 0; i < n; i++) begin
      w = 16'($urandom);
      if (kind < 85 && i == 0) w = {4'h4, 4'(ihl), w[7:0]};
      if (kind < 85 && i == 1) w = 16'(tl);
      send_word(w, i == n - 1, 1'b0, '0);
    end
  endtask

  // receiver: random stall, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : mon
    result_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        quiet_cycles <= 0;
        got = '{out_word_o, out_last_o, ip_check_o, tcp_check_o, pkt_status_o};
        if (pending_words.size() == 0) begin
          if (fail_count < REPORT_MAX)
            $display("unexpected transaction: word %h last %b ip %h tcp %h status %b",
                     got.out_word, got.out_last, got.ip_check, got.tcp_check,
                     got.pkt_status);
          fail_count <= fail_count + 1;
        end else begin
          want = pending_words.pop_front();
          if (got !== want) begin
            if (fail_count < REPORT_MAX)
              $display("mismatch: exp %h/%b/%h/%h/%b got %h/%b/%h/%h/%b",
                       want.out_word, want.out_last, want.ip_check, want.tcp_check,
                       want.pkt_status, got.out_word, got.out_last, got.ip_check,
                       got.tcp_check, got.pkt_status);
            fail_count <= fail_count + 1;
          end
        end
      end else if (in_valid_i && !in_stall_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned ph, sent, n;
    logic [15:0] offs;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 36;
    rx_idle_pct = 70;
    write_offset(16'h01F0);
    foreach (dir_rows[k])
      send_word(dir_rows[k].word, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].res);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1: begin
          tx_idle_pct = 36;
          rx_idle_pct = 70;
        end
        2, 3: begin
          tx_idle_pct = 70;
          rx_idle_pct = 36;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      case (ph)
        0: offs = 16'hFFFF;
        2: offs = 16'h0001;
        4: offs = 16'h0000;
        5: offs = 16'h00FF;
        default: offs = 16'($urandom);
      endcase
      write_offset(offs);
      if (ph == 4) hold_req <= 1'b1;
      sent = 0;
      while (sent < PHASE_WORDS) begin
        send_packet(n);
        sent += n;
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- ipv4_tcp_rewrite_checksum_top.f -----
+incdir+sv
sv/itrc_pkg.sv
sv/itrc_in_reg.sv
sv/itrc_core.sv
sv/ipv4_tcp_rewrite_checksum_top.sv
tb/tb_top.sv
